@@ hdl/rsc_pkg.sv @@
package rsc_pkg;

	localparam int VAL_W  = 16;
	localparam int NUM_W  = 34;
	localparam int DEN_W  = 17;
	localparam int MAG_W  = 33;
	localparam int DVS_W  = 27;
	localparam int CELLS  = MAG_W;

	localparam logic [MAG_W-1:0] SMALL_LIMIT = 33'd2147483;
	localparam logic [MAG_W-1:0] ROUND_SCALE = 33'd1000;
	localparam logic [MAG_W-1:0] ROUND_HALF  = 33'd500;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_IN_LOW   = 2'd0,
		REG_IN_HIGH  = 2'd1,
		REG_OUT_LOW  = 2'd2,
		REG_OUT_HIGH = 2'd3
	} reg_index_t;

	// one division in flight: partial remainder, dividend bits still to
	// shift in, quotient so far, divisor and result sign
	typedef struct packed {
		logic [DVS_W-1:0] rem;
		logic [MAG_W-1:0] dnd;
		logic [MAG_W-1:0] quo;
		logic [DVS_W-1:0] dvs;
		logic             neg;
	} rsc_div_t;

endpackage

@@ hdl/rsc_div_cell.sv @@
module rsc_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rsc_pkg::rsc_div_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rsc_pkg::rsc_div_t out_data
);
	import rsc_pkg::*;

	logic              valid_q;
	rsc_div_t          data_q;
	rsc_div_t          nxt;
	logic [DVS_W:0]    trial;
	logic              ge;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {in_data.rem, in_data.dnd[MAG_W-1]};
		ge       = trial >= {1'b0, in_data.dvs};
		nxt      = in_data;
		nxt.rem  = ge ? DVS_W'(trial - {1'b0, in_data.dvs}) : trial[DVS_W-1:0];
		nxt.dnd  = {in_data.dnd[MAG_W-2:0], 1'b0};
		nxt.quo  = {in_data.quo[MAG_W-2:0], ge};
	end

	assign in_stall  = valid_q & out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// advance when the next cell takes the request or this one is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_q <= nxt;
		end
	end

endmodule

@@ hdl/rsc_front.sv @@
module rsc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [rsc_pkg::VAL_W-1:0]    value,
	input  logic signed [rsc_pkg::VAL_W-1:0]    in_low,
	input  logic signed [rsc_pkg::VAL_W-1:0]    in_high,
	input  logic signed [rsc_pkg::VAL_W-1:0]    out_low,
	input  logic signed [rsc_pkg::VAL_W-1:0]    out_high,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rsc_pkg::rsc_div_t                   out_data
);
	import rsc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic st1, st2, st3, st4;

	logic signed [DEN_W-1:0]     dh_s1, dl_s1;
	logic signed [2*DEN_W-2:0]   p1_s2, p2_s2;
	logic signed [NUM_W-1:0]     num_s3;
	logic signed [DEN_W-1:0]     den_s3;
	rsc_div_t                    div_s4;

	logic                        empty;
	logic signed [NUM_W-1:0]     num_c;
	logic [MAG_W-1:0]            mag_a;
	logic [MAG_W-1:0]            mag_b;
	logic                        pos;
	logic                        rnd;
	rsc_div_t                    div_c;

	assign st4      = v_s4 & out_stall;
	assign st3      = v_s3 & st4;
	assign st2      = v_s2 & st3;
	assign st1      = v_s1 & st2;
	assign in_stall = st1;

	assign empty = in_low == in_high;
	assign num_c = NUM_W'(p1_s2) - NUM_W'(p2_s2);

	// magnitudes, sign and rounding choice
	always_comb begin
		mag_a = num_s3[NUM_W-1] ? MAG_W'(-num_s3) : MAG_W'(num_s3);
		mag_b = den_s3[DEN_W-1] ? MAG_W'(-den_s3) : MAG_W'(den_s3);
		pos   = num_s3[NUM_W-1] == den_s3[DEN_W-1];
		rnd   = pos && (mag_a < SMALL_LIMIT);
		div_c.rem = '0;
		div_c.quo = '0;
		div_c.neg = !pos;
		if (rnd) begin
			div_c.dnd = mag_a * ROUND_SCALE + mag_b * ROUND_HALF;
			div_c.dvs = DVS_W'(mag_b * ROUND_SCALE);
		end else begin
			div_c.dnd = mag_a;
			div_c.dvs = DVS_W'(mag_b);
		end
	end

	// hold valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (!st1) v_s1 <= in_valid;
			if (!st2) v_s2 <= v_s1;
			if (!st3) v_s3 <= v_s2;
			if (!st4) v_s4 <= v_s3;
		end
	end

	// differences, products, numerator, divider operands
	always_ff @(posedge clk) begin
		if (!st1 && in_valid) begin
			dh_s1 <= DEN_W'(value) - DEN_W'(in_high);
			dl_s1 <= DEN_W'(value) - DEN_W'(in_low);
		end
		if (!st2 && v_s1) begin
			p1_s2 <= dh_s1 * out_low;
			p2_s2 <= dl_s1 * out_high;
		end
		if (!st3 && v_s2) begin
			num_s3 <= empty ? NUM_W'(out_low) : num_c;
			den_s3 <= empty ? DEN_W'(1) : DEN_W'(in_low) - DEN_W'(in_high);
		end
		if (!st4 && v_s3) begin
			div_s4 <= div_c;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = div_s4;

endmodule

@@ hdl/range_scaler_rounded_unit.sv @@
// Pipeline: 38 register stages (4 setup stages, one divider cell per quotient
// bit for 33 bits, one clip/output stage).
// Throughput: one request per cycle unless the output stalls; every stage
// holds its own valid bit, so bubbles close up while the output is stalled.
// Reset: arst_n clears all valid bits and loads in_low 0, in_high 127,
// out_low 0, out_high 127.
module range_scaler_rounded_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [rsc_pkg::VAL_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [rsc_pkg::VAL_W-1:0]   value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [rsc_pkg::VAL_W-1:0]   scaled
);
	import rsc_pkg::*;

	logic signed [VAL_W-1:0] in_low_q, in_high_q, out_low_q, out_high_q;

	logic      cv   [CELLS+1];
	logic      cst  [CELLS+1];
	rsc_div_t  cd   [CELLS+1];

	logic                    valid_q;
	logic                    last_stall;
	logic signed [MAG_W+1:0] res;
	logic signed [MAG_W+1:0] lo, hi;
	logic signed [VAL_W-1:0] clip;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_low_q   <= 16'sd0;
			in_high_q  <= 16'sd127;
			out_low_q  <= 16'sd0;
			out_high_q <= 16'sd127;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_IN_LOW:   in_low_q   <= cfg_data;
				REG_IN_HIGH:  in_high_q  <= cfg_data;
				REG_OUT_LOW:  out_low_q  <= cfg_data;
				REG_OUT_HIGH: out_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.in_low    (in_low_q),
		.in_high   (in_high_q),
		.out_low   (out_low_q),
		.out_high  (out_high_q),
		.out_valid (cv[0]),
		.out_stall (cst[0]),
		.out_data  (cd[0])
	);

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		rsc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_stall  (cst[i]),
			.in_data   (cd[i]),
			.out_valid (cv[i+1]),
			.out_stall (cst[i+1]),
			.out_data  (cd[i+1])
		);
	end

	// apply sign and clip to the target range
	always_comb begin
		res = cd[CELLS].neg ? -$signed({2'b00, cd[CELLS].quo})
		                    :  $signed({2'b00, cd[CELLS].quo});
		lo  = (out_low_q < out_high_q) ? (MAG_W+2)'(out_low_q) : (MAG_W+2)'(out_high_q);
		hi  = (out_low_q < out_high_q) ? (MAG_W+2)'(out_high_q) : (MAG_W+2)'(out_low_q);
		if (res < lo) begin
			clip = VAL_W'(lo);
		end else if (res > hi) begin
			clip = VAL_W'(hi);
		end else begin
			clip = VAL_W'(res);
		end
	end

	assign last_stall  = valid_q & out_stall;
	assign cst[CELLS]  = last_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!last_stall) begin
			valid_q <= cv[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (!last_stall && cv[CELLS]) begin
			scaled <= clip;
		end
	end

	assign out_valid = valid_q;

endmodule

@@ tb/range_scaler_rounded_checker.sv @@
`timescale 1ns / 1ps

module range_scaler_rounded_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [rsc_pkg::VAL_W-1:0]        cfg_data,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic signed [rsc_pkg::VAL_W-1:0] value,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic signed [rsc_pkg::VAL_W-1:0] scaled,
	output int                               fail_count,
	output int                               pending
);
	import rsc_pkg::*;

	logic signed [15:0] map_in_low, map_in_high, map_out_low, map_out_high;
	logic signed [15:0] scaled_queue[$];

	// compute the mapped, rounded and clipped value
	function automatic logic signed [15:0] map_point(input logic signed [15:0] v);
		longint num, den, q, lo, hi;
		longint lim;
		begin
			lim = 64'sd2147483;
			if (map_in_low == map_in_high) begin
				num = map_out_low;
				den = 1;
			end else begin
				num = (longint'(v) - map_in_high) * map_out_low
					- (longint'(v) - map_in_low) * map_out_high;
				den = longint'(map_in_low) - map_in_high;
			end
			if (num < lim && num > -lim) begin
				q = (1000 * num) / den;
				num = q / 1000 + (((q % 1000) >= 500) ? 1 : 0);
			end else begin
				num = num / den;
			end
			lo = (map_out_low < map_out_high) ? map_out_low : map_out_high;
			hi = (map_out_low < map_out_high) ? map_out_high : map_out_low;
			if (num < lo) num = lo;
			if (num > hi) num = hi;
			return num[15:0];
		end
	endfunction

	assign pending = scaled_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			map_in_low <= 0;
			map_in_high <= 127;
			map_out_low <= 0;
			map_out_high <= 127;
			fail_count <= 0;
			scaled_queue.delete();
		end else begin
			// predict each accepted request with the current settings
			if (in_valid && !in_stall)
				scaled_queue.push_back(map_point(value));
			// compare each accepted result with the oldest prediction
			if (out_valid && !out_stall) begin
				if (scaled_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result scaled=%0d", scaled);
				end else begin
					want = scaled_queue.pop_front();
					if (want !== scaled) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch scaled: expected %0d got %0d", want, scaled);
					end
				end
			end
			// track register writes
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_IN_LOW: map_in_low <= cfg_data;
					REG_IN_HIGH: map_in_high <= cfg_data;
					REG_OUT_LOW: map_out_low <= cfg_data;
					REG_OUT_HIGH: map_out_high <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

@@ tb/tb_range_scaler_rounded_unit.sv @@
`timescale 1ns / 1ps

module tb_range_scaler_rounded_unit;
	import rsc_pkg::*;

	logic clk, arst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic signed [15:0] value, scaled;
	int fail_count, pending;
	int send_idle, recv_idle;
	bit hold_recv;

	range_scaler_rounded_unit dut (.*);
	range_scaler_rounded_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random stall, or a long hold-off on request
	initial begin
		int i;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_recv) begin
				out_stall <= 1;
				for (i = 0; i < 200; i++) @(posedge clk);
				hold_recv = 0;
				out_stall <= 0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [15:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	// write all four range registers, then drop the write enable
	task automatic set_ranges(input logic [15:0] il, ih, ol, oh);
		write_reg(REG_IN_LOW, il);
		write_reg(REG_IN_HIGH, ih);
		write_reg(REG_OUT_LOW, ol);
		write_reg(REG_OUT_HIGH, oh);
		cfg_we <= 0;
	endtask

	// offer one request, hold it until accepted
	task automatic send_value(input logic [15:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// let the pipeline drain before touching registers
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(300) - 150);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int p, n;
		logic [15:0] a, b;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; value = 0;
		send_idle = 0; recv_idle = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: default ranges, extremes, empty and reversed ranges
		send_value(16'h0); send_value(16'd127); send_value(16'd63);
		send_value(16'h8000); send_value(16'h7fff); send_value(16'hffff);
		drain();
		set_ranges(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send_value(16'h8000); send_value(16'h7fff); send_value(16'h0);
		send_value(16'h1); send_value(16'hffff);
		drain();
		set_ranges(16'd5, 16'd5, 16'hfff0, 16'd100);
		send_value(16'd5); send_value(16'h8000); send_value(16'h7fff);
		drain();
		set_ranges(16'd0, 16'd3, 16'd0, 16'hfff6);
		for (p = -4; p < 5; p++) send_value(16'(p));
		drain();

		// random phases with shifting idle rates
		for (p = 0; p < 3; p++) begin
			send_idle = (p == 0) ? 21 : (p == 1) ? 55 : 0;
			recv_idle = (p == 0) ? 55 : (p == 1) ? 21 : 0;
			for (n = 0; n < 5; n++) begin
				a = ($urandom_range(3) == 0) ? 16'($urandom)
					: 16'($urandom_range(2000) - 1000);
				b = ($urandom_range(7) == 0) ? a
					: 16'(a + $urandom_range(500) - 250);
				set_ranges(a, b,
					$urandom_range(1) ? 16'($urandom) : 16'($urandom_range(400) - 200),
					$urandom_range(1) ? 16'($urandom) : 16'($urandom_range(400) - 200));
				if (p == 2 && n == 0) hold_recv = 1;
				repeat (50) send_value(pick_value());
				drain();
			end
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
